@@ sv/srft_pkg.sv @@
package srft_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int CARD_SLOTS    = 16;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W         = 5;

	localparam int IN_W  = 48;
	localparam int OUT_W = 16;

	localparam logic [2:0] OP_QUERY = 3'd0;
	localparam logic [2:0] OP_MARKV = 3'd1;
	localparam logic [2:0] OP_MARKC = 3'd2;
	localparam logic [2:0] OP_TICK  = 3'd3;
	localparam logic [2:0] OP_SWEEP = 3'd4;

	localparam logic [1:0] KIND_TREE  = 2'd0;
	localparam logic [1:0] KIND_FRAME = 2'd1;
	localparam logic [1:0] KIND_CARD  = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0] removed_count;
		logic             table_full;
		logic             entry_added;
		logic             session_found;
		logic             refresh_needed;
	} result_t;

	// one-hot card select; numbers beyond the slot count select nothing
	function automatic logic [CARD_SLOTS-1:0] card_mask(input logic [3:0] card);
		logic [CARD_SLOTS-1:0] m;
		for (int i = 0; i < CARD_SLOTS; i++) begin
			m[i] = (card == 4'(i));
		end
		return m;
	endfunction

endpackage

@@ sv/session_refresh_flag_table.sv @@
// Session table of TABLE_ENTRIES entries with per-session view and card change bits.
// One word is taken at a time; s_tready is high only while the sequencer is idle.
// Query, mark-views, mark-card and sweep walk the table one entry per cycle with a
// single key compare / idle-time subtract; a query stops at the entry that hits, and a
// tick or an unused operation skips the walk and goes straight to its result. The
// result sits in an output register, so the next word may be accepted while it waits;
// a result still waiting there when the following one is ready holds the sequencer
// until it is taken. The user must write idle_limit via cfg_we/cfg_wdata only while
// the block is idle; the block itself does not enforce this. Reset value is 300.
module session_refresh_flag_table import srft_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// operation[2:0], session_key[34:3], query_kind[36:35], card_number[40:37],
	// view_mask[42:41], zero fill
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// refresh_needed[0], session_found[1], entry_added[2], table_full[3],
	// removed_count[8:4], zero fill
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	state_t state_q, state_d;

	logic [IDX_W-1:0] idx_q;
	logic [2:0]       op_q;
	logic [31:0]      key_q;
	logic [1:0]       kind_q;
	logic [3:0]       card_q;
	logic [1:0]       vmask_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	result_t          res_q;
	result_t          out_q;
	logic             out_valid_q;
	logic [31:0]      seconds_q;
	logic [15:0]      idle_limit_q;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0]              key_mem   [TABLE_ENTRIES];
	logic [31:0]              seen_mem  [TABLE_ENTRIES];
	logic [1:0]               view_mem  [TABLE_ENTRIES];
	logic [CARD_SLOTS-1:0]    cards_mem [TABLE_ENTRIES];

	logic                  accept;
	logic                  cur_valid;
	logic                  cur_hit;
	logic                  cur_stale;
	logic                  is_last;
	logic                  free_any;
	logic [IDX_W-1:0]      free_now;
	logic [31:0]           idle_time;
	logic [CARD_SLOTS-1:0] cmask;
	logic                  cur_refresh;
	logic                  out_free;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cur_valid = valid_q[idx_q];
	assign cur_hit   = cur_valid && (key_mem[idx_q] == key_q);
	assign idle_time = seconds_q - seen_mem[idx_q];
	assign cur_stale = cur_valid && (idle_time > {16'd0, idle_limit_q});
	assign is_last   = (idx_q == LAST_IDX);
	assign free_any  = free_found_q || !cur_valid;
	assign free_now  = free_found_q ? free_idx_q : idx_q;
	assign cmask     = card_mask(card_q);
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		unique case (kind_q)
			KIND_TREE:  cur_refresh = view_mem[idx_q][0];
			KIND_FRAME: cur_refresh = view_mem[idx_q][1];
			KIND_CARD:  cur_refresh = |(cards_mem[idx_q] & cmask);
			KIND_NONE:  cur_refresh = 1'b0;
			default:    cur_refresh = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tdata[2:0] == OP_QUERY || s_tdata[2:0] == OP_MARKV ||
					    s_tdata[2:0] == OP_MARKC || s_tdata[2:0] == OP_SWEEP) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (is_last || (op_q == OP_QUERY && cur_hit)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer control, counters and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			res_q        <= '0;
			seconds_q    <= '0;
			idle_limit_q <= 16'd300;
			valid_q      <= '0;
		end else begin
			if (cfg_we) begin
				idle_limit_q <= cfg_wdata;
			end
			if (accept) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
				res_q        <= '0;
				if (s_tdata[2:0] == OP_TICK) begin
					seconds_q <= seconds_q + 32'd1;
				end
			end else if (state_q == ST_SCAN) begin
				idx_q <= idx_q + IDX_W'(1);
				unique case (op_q)
					OP_QUERY: begin
						if (cur_hit) begin
							res_q.session_found  <= 1'b1;
							res_q.refresh_needed <= cur_refresh;
						end else begin
							if (!cur_valid && !free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= idx_q;
							end
							if (is_last) begin
								if (free_any) begin
									valid_q[free_now] <= 1'b1;
									res_q.entry_added <= 1'b1;
								end else begin
									res_q.table_full  <= 1'b1;
								end
							end
						end
					end
					OP_SWEEP: begin
						if (cur_stale) begin
							valid_q[idx_q] <= 1'b0;
							if (res_q.removed_count != '1) begin
								res_q.removed_count <= res_q.removed_count + CNT_W'(1);
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// input word and entry payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tdata[2:0];
			key_q   <= s_tdata[34:3];
			kind_q  <= s_tdata[36:35];
			card_q  <= s_tdata[40:37];
			vmask_q <= s_tdata[42:41];
		end
		if (state_q == ST_SCAN) begin
			unique case (op_q)
				OP_QUERY: begin
					if (cur_hit) begin
						seen_mem[idx_q] <= seconds_q;
						if (kind_q == KIND_TREE) begin
							view_mem[idx_q] <= view_mem[idx_q] & 2'b10;
						end else if (kind_q == KIND_FRAME) begin
							view_mem[idx_q] <= view_mem[idx_q] & 2'b01;
						end else if (kind_q == KIND_CARD) begin
							cards_mem[idx_q] <= cards_mem[idx_q] & ~cmask;
						end
					end else if (is_last && free_any) begin
						key_mem[free_now]   <= key_q;
						seen_mem[free_now]  <= seconds_q;
						view_mem[free_now]  <= '0;
						cards_mem[free_now] <= '0;
					end
				end
				OP_MARKV: begin
					if (cur_valid) begin
						view_mem[idx_q] <= view_mem[idx_q] | vmask_q;
					end
				end
				OP_MARKC: begin
					if (cur_valid) begin
						cards_mem[idx_q] <= cards_mem[idx_q] | cmask;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_W - $bits(result_t))'(0), out_q};

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0({out_q.session_found, out_q.entry_added, out_q.table_full}))
		else $error("query outcome flags not exclusive");

	a_sweep_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.removed_count != '0) |->
			!(out_q.session_found || out_q.entry_added || out_q.table_full))
		else $error("removed count alongside query flags");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("ready straight after accept");

	a_alloc_one: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(valid_q) <= $countones($past(valid_q)) + 1))
		else $error("more than one entry allocated at once");

endmodule
